[rtl/fpba_pkg.sv]
// types, constants and helper functions for the fit-policy block allocator
// used by every rtl file of the block; depends on nothing else
`default_nettype none

package fpba_pkg;

   // table geometry
   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W      = SIZE_BITS + $clog2(NUM_BLOCKS);

   // port field widths
   localparam int ACT_FIELD_W  = 1;
   localparam int IDX_FIELD_W  = 4;
   localparam int SIZE_FIELD_W = 16;
   localparam int TOTAL_W      = 20;
   localparam int TOTAL_MAX    = (2 ** TOTAL_W) - 1;

   // command queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_BLOCKS - 1);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_BLOCKS);
   localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   // allocation policy register codes
   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_WORST = 2'd2,
      POL_NEXT  = 2'd3
   } policy_type;

   // item kinds
   typedef enum logic [ACT_FIELD_W-1:0] {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef struct packed {
      logic [ACT_FIELD_W-1:0]  action;
      logic [IDX_FIELD_W-1:0]  block_index;
      logic [SIZE_FIELD_W-1:0] size;
   } req_type;

   typedef struct packed {
      logic                    granted;
      logic [IDX_FIELD_W-1:0]  chosen_block;
      logic [SIZE_FIELD_W-1:0] block_left;
      logic [TOTAL_W-1:0]      internal_total;
      logic [TOTAL_W-1:0]      external_total;
   } rsp_type;

   // classified item as it waits in the command queue
   typedef struct packed {
      op_type               op;
      logic                 in_range;
      logic [IDX_W-1:0]     idx;
      logic [SIZE_BITS-1:0] size;
   } cmd_type;

   function automatic logic [SIZE_BITS-1:0] size_from_field(
      input logic [SIZE_FIELD_W-1:0] v);
      logic [SIZE_BITS+SIZE_FIELD_W-1:0] w;
      w = {{SIZE_BITS{1'b0}}, v};
      return w[SIZE_BITS-1:0];
   endfunction

   function automatic logic [SIZE_FIELD_W-1:0] size_to_field(
      input logic [SIZE_BITS-1:0] v);
      logic [SIZE_BITS+SIZE_FIELD_W-1:0] w;
      w = {{SIZE_FIELD_W{1'b0}}, v};
      return w[SIZE_FIELD_W-1:0];
   endfunction

   function automatic logic idx_in_range(input logic [IDX_FIELD_W-1:0] v);
      logic [IDX_W+IDX_FIELD_W:0] w;
      w = {{(IDX_W + 1){1'b0}}, v};
      return w < (IDX_W + IDX_FIELD_W + 1)'(NUM_BLOCKS);
   endfunction

   function automatic logic [IDX_W-1:0] idx_from_field(
      input logic [IDX_FIELD_W-1:0] v);
      logic [IDX_W+IDX_FIELD_W-1:0] w;
      w = {{IDX_W{1'b0}}, v};
      return w[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_FIELD_W-1:0] idx_to_field(input logic [IDX_W-1:0] v);
      logic [IDX_W+IDX_FIELD_W-1:0] w;
      w = {{IDX_FIELD_W{1'b0}}, v};
      return w[IDX_FIELD_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] size_to_sum(input logic [SIZE_BITS-1:0] v);
      logic [SUM_W+SIZE_BITS-1:0] w;
      w = {{SUM_W{1'b0}}, v};
      return w[SUM_W-1:0];
   endfunction

   // clamp a running sum to the total field
   function automatic logic [TOTAL_W-1:0] sat_total(input logic [SUM_W-1:0] s);
      logic [SUM_W+TOTAL_W-1:0] w;
      w = {{TOTAL_W{1'b0}}, s};
      if (w > (SUM_W + TOTAL_W)'(TOTAL_MAX)) begin
         return {TOTAL_W{1'b1}};
      end
      return w[TOTAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/fpba_front.sv]
// front end: accepts items, classifies them and holds them in a short queue
// depends on fpba_pkg
`default_nettype none

module fpba_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire fpba_pkg::req_type req_data,
   input  wire logic              cmd_pop,
   output logic                   cmd_empty,
   output fpba_pkg::cmd_type      cmd_head
);

   fpba_pkg::cmd_type                q_ff [fpba_pkg::QUEUE_DEPTH];
   fpba_pkg::cmd_type                cmd_in;
   logic [fpba_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fpba_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fpba_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             push_acc;
   logic                             pop_acc;

   // classify the incoming item
   always_comb begin
      cmd_in.op       = fpba_pkg::op_type'(req_data.action);
      cmd_in.in_range = fpba_pkg::idx_in_range(req_data.block_index);
      cmd_in.idx      = fpba_pkg::idx_from_field(req_data.block_index);
      cmd_in.size     = fpba_pkg::size_from_field(req_data.size);
   end

   // queue flags and handshakes
   assign req_full  = (count_ff == fpba_pkg::QUEUE_FULL_CNT);
   assign cmd_empty = (count_ff == '0);
   assign push_acc  = req_push && !req_full;
   assign pop_acc   = cmd_pop && !cmd_empty;
   assign cmd_head  = q_ff[rd_ptr_ff];

   // pointer and count next values
   always_comb begin
      wr_ptr_in = push_acc ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_acc ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push_acc, pop_acc})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_acc) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fpba_pkg::QUEUE_FULL_CNT)
      else $error("command queue count past depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push_acc && !pop_acc) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

[rtl/fpba_back.sv]
// back end: block table, fit search sequencer, fragmentation totals, result register
// depends on fpba_pkg
`default_nettype none

module fpba_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cmd_empty,
   input  wire fpba_pkg::cmd_type         cmd_head,
   output logic                           cmd_pop,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_data,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output fpba_pkg::rsp_type              rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   state_type                         state_ff;
   fpba_pkg::policy_type              policy_ff;
   fpba_pkg::cmd_type                 cmd_ff;
   logic [fpba_pkg::IDX_W-1:0]        next_ptr_ff;
   logic [fpba_pkg::NUM_BLOCKS-1:0]   used_ff;
   logic [fpba_pkg::NUM_BLOCKS-1:0]   blk_vld_ff;
   logic [fpba_pkg::SIZE_BITS-1:0]    mem_ff [fpba_pkg::NUM_BLOCKS];
   logic [fpba_pkg::SIZE_BITS-1:0]    rd_data_ff;
   logic                              rd_hit_ff;
   logic [fpba_pkg::IDX_W-1:0]        addr_ff;
   logic [fpba_pkg::IDX_W-1:0]        rd_idx_ff;
   logic [fpba_pkg::CNT_W-1:0]        cnt_ff;
   logic                              rd_pend_ff;
   logic                              found_ff;
   logic [fpba_pkg::IDX_W-1:0]        best_idx_ff;
   logic [fpba_pkg::SIZE_BITS-1:0]    best_val_ff;
   logic [fpba_pkg::SUM_W-1:0]        ext_sum_ff, ext_sum_in;
   logic [fpba_pkg::SUM_W-1:0]        int_sum_ff, int_sum_in;
   fpba_pkg::rsp_type                 res_ff;
   fpba_pkg::rsp_type                 out_ff;
   logic                              out_vld_ff;

   logic [fpba_pkg::IDX_W-1:0]        rd_addr;
   logic [fpba_pkg::SIZE_BITS-1:0]    rd_word;
   logic                              wr_en;
   logic [fpba_pkg::IDX_W-1:0]        wr_addr;
   logic [fpba_pkg::SIZE_BITS-1:0]    wr_data;
   logic [fpba_pkg::SIZE_BITS-1:0]    new_left;
   logic                              fits;
   logic                              take;
   logic [fpba_pkg::IDX_W-1:0]        scan_start;
   logic [fpba_pkg::IDX_W-1:0]        addr_next;
   logic                              load_ok;
   logic                              alloc_ok;

   assign csr_ready = 1'b1;
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   // table read port address and entries never written read as zero
   assign rd_addr = (state_ff == ST_LOAD_RD) ? cmd_ff.idx : addr_ff;
   assign rd_word = rd_hit_ff ? rd_data_ff : '0;

   // fit test on the entry that just came out of the table
   assign fits = (rd_word >= cmd_ff.size);
   always_comb begin
      unique case (policy_ff)
         fpba_pkg::POL_BEST:  take = fits && (!found_ff || (rd_word < best_val_ff));
         fpba_pkg::POL_WORST: take = fits && (!found_ff || (rd_word > best_val_ff));
         default:             take = fits && !found_ff;
      endcase
   end

   assign scan_start = (policy_ff == fpba_pkg::POL_NEXT) ? next_ptr_ff : '0;
   assign addr_next  = (addr_ff == fpba_pkg::IDX_LAST) ? '0 : addr_ff + 1'b1;

   // table write and running totals
   assign load_ok  = (state_ff == ST_LOAD_WR) && cmd_ff.in_range;
   assign alloc_ok = (state_ff == ST_COMMIT) && found_ff;
   assign new_left = best_val_ff - cmd_ff.size;

   always_comb begin
      wr_en      = load_ok || alloc_ok;
      wr_addr    = load_ok ? cmd_ff.idx : best_idx_ff;
      wr_data    = load_ok ? cmd_ff.size : new_left;
      ext_sum_in = ext_sum_ff;
      int_sum_in = int_sum_ff;
      if (load_ok) begin
         ext_sum_in = ext_sum_ff - fpba_pkg::size_to_sum(rd_word)
                      + fpba_pkg::size_to_sum(cmd_ff.size);
         if (used_ff[cmd_ff.idx]) begin
            int_sum_in = int_sum_ff - fpba_pkg::size_to_sum(rd_word);
         end
      end else if (alloc_ok) begin
         ext_sum_in = ext_sum_ff - fpba_pkg::size_to_sum(cmd_ff.size);
         if (used_ff[best_idx_ff]) begin
            int_sum_in = int_sum_ff - fpba_pkg::size_to_sum(cmd_ff.size);
         end else begin
            int_sum_in = int_sum_ff + fpba_pkg::size_to_sum(new_left);
         end
      end
   end

   // block table memory
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      rd_hit_ff  <= blk_vld_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // written marks for the table
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_vld_ff <= '0;
      end else if (wr_en) begin
         blk_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         policy_ff   <= fpba_pkg::POL_FIRST;
         next_ptr_ff <= '0;
         used_ff     <= '0;
         ext_sum_ff  <= '0;
         int_sum_ff  <= '0;
         cnt_ff      <= '0;
         rd_pend_ff  <= 1'b0;
         found_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            policy_ff <= fpba_pkg::policy_type'(csr_data);
         end
         // result slot drains on pop unless a new result refills it
         if (rsp_pop && out_vld_ff && (state_ff != ST_RESP)) begin
            out_vld_ff <= 1'b0;
         end
         ext_sum_ff <= ext_sum_in;
         int_sum_ff <= int_sum_in;

         unique case (state_ff)
            ST_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff     <= cmd_head;
                  addr_ff    <= scan_start;
                  cnt_ff     <= '0;
                  rd_pend_ff <= 1'b0;
                  found_ff   <= 1'b0;
                  state_ff   <= (cmd_head.op == fpba_pkg::OP_LOAD) ? ST_LOAD_RD : ST_SCAN;
               end
            end

            ST_LOAD_RD: begin
               state_ff <= ST_LOAD_WR;
            end

            ST_LOAD_WR: begin
               res_ff.internal_total <= fpba_pkg::sat_total(int_sum_in);
               res_ff.external_total <= fpba_pkg::sat_total(ext_sum_in);
               if (cmd_ff.in_range) begin
                  used_ff[cmd_ff.idx]  <= 1'b0;
                  res_ff.granted       <= 1'b1;
                  res_ff.chosen_block  <= fpba_pkg::idx_to_field(cmd_ff.idx);
                  res_ff.block_left    <= fpba_pkg::size_to_field(cmd_ff.size);
               end else begin
                  res_ff.granted       <= 1'b0;
                  res_ff.chosen_block  <= '0;
                  res_ff.block_left    <= '0;
               end
               state_ff <= ST_RESP;
            end

            // one table read issued and one entry compared per cycle
            ST_SCAN: begin
               if (rd_pend_ff && take) begin
                  found_ff    <= 1'b1;
                  best_idx_ff <= rd_idx_ff;
                  best_val_ff <= rd_word;
               end
               if (cnt_ff != fpba_pkg::SCAN_LAST) begin
                  rd_idx_ff  <= addr_ff;
                  addr_ff    <= addr_next;
                  cnt_ff     <= cnt_ff + 1'b1;
                  rd_pend_ff <= 1'b1;
               end else begin
                  rd_pend_ff <= 1'b0;
                  state_ff   <= ST_COMMIT;
               end
            end

            ST_COMMIT: begin
               res_ff.internal_total <= fpba_pkg::sat_total(int_sum_in);
               res_ff.external_total <= fpba_pkg::sat_total(ext_sum_in);
               if (found_ff) begin
                  used_ff[best_idx_ff] <= 1'b1;
                  next_ptr_ff          <= best_idx_ff;
                  res_ff.granted       <= 1'b1;
                  res_ff.chosen_block  <= fpba_pkg::idx_to_field(best_idx_ff);
                  res_ff.block_left    <= fpba_pkg::size_to_field(new_left);
               end else begin
                  res_ff.granted       <= 1'b0;
                  res_ff.chosen_block  <= '0;
                  res_ff.block_left    <= '0;
               end
               state_ff <= ST_RESP;
            end

            ST_RESP: begin
               if (!out_vld_ff || rsp_pop) begin
                  out_ff     <= res_ff;
                  out_vld_ff <= 1'b1;
                  state_ff   <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= fpba_pkg::SCAN_LAST)
      else $error("scan counter past table end");

   a_next_ptr: assert property (@(posedge clock) disable iff (reset)
      next_ptr_ff <= fpba_pkg::IDX_LAST)
      else $error("next-fit pointer out of table");

   a_frag_order: assert property (@(posedge clock) disable iff (reset)
      int_sum_ff <= ext_sum_ff)
      else $error("internal total above external total");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && found_ff) |-> (best_val_ff >= cmd_ff.size))
      else $error("picked block too small");

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && out_vld_ff && !rsp_pop) |=> (state_ff == ST_RESP))
      else $error("result dropped while output slot busy");

endmodule

`default_nettype wire

[rtl/fit_policy_block_allocator.sv]
// fit-policy block allocator: a load item passes from queue head through the load read,
// load write and response states to the result; a request item walks the whole table
// through the single table read port, one entry per cycle, then commits; one item at a time.
// a two-entry command queue takes items while the back end works, and a result
// register holds the last result until popped.
// synchronous reset empties queue and result register, zeroes the block table
// through per-entry written marks, clears used marks, pointer, totals, policy = first fit
`default_nettype none

module fit_policy_block_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire fpba_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output fpba_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_data
);

   logic              cmd_pop;
   logic              cmd_empty;
   fpba_pkg::cmd_type cmd_head;

   // front end with command queue
   fpba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head)
   );

   // back end with table, search and result register
   fpba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[test/fpba_result_checker.sv]
`timescale 1ns / 1ps
// result checker for the fit-policy block allocator: keeps its own block table,
// predicts each item's result and compares it with what the block pops
// depends on fpba_pkg for the item, result and policy types
module fpba_result_checker
   import fpba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  req_type    req_data,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_data,
   output int         fail_count,
   output int         pending_count
);

   // shadow of the block's state
   logic [SIZE_FIELD_W-1:0] free_size [NUM_BLOCKS];
   logic                    used_flag [NUM_BLOCKS];
   logic [IDX_FIELD_W-1:0]  last_grant;
   policy_type              fit_policy;

   rsp_type outcome_fifo[$];
   int      mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // apply one item to the shadow table and return the result it causes
   function automatic rsp_type place_item(input req_type item);
      rsp_type     outcome;
      int          pick;
      int          idx;
      int          start;
      int          k;
      int unsigned in_sum;
      int unsigned ex_sum;
      outcome = '0;
      if (item.action == OP_LOAD) begin
         if (int'(item.block_index) < NUM_BLOCKS) begin
            free_size[item.block_index] = item.size;
            used_flag[item.block_index] = 1'b0;
            outcome.granted      = 1'b1;
            outcome.chosen_block = item.block_index;
            outcome.block_left   = item.size;
         end
      end else begin
         pick  = -1;
         start = int'(last_grant);
         if (start >= NUM_BLOCKS) begin
            start = 0;
         end
         for (k = 0; k < NUM_BLOCKS; k++) begin
            case (fit_policy)
               POL_FIRST: begin
                  if (pick < 0 && free_size[k] >= item.size) pick = k;
               end
               POL_BEST: begin
                  if (free_size[k] >= item.size &&
                      (pick < 0 || free_size[k] < free_size[pick])) pick = k;
               end
               POL_WORST: begin
                  if (free_size[k] >= item.size &&
                      (pick < 0 || free_size[k] > free_size[pick])) pick = k;
               end
               default: begin
                  // search from the last grant, wrapping once
                  idx = (start + k) % NUM_BLOCKS;
                  if (pick < 0 && free_size[idx] >= item.size) pick = idx;
               end
            endcase
         end
         if (pick >= 0) begin
            free_size[pick] = free_size[pick] - item.size;
            used_flag[pick] = 1'b1;
            last_grant      = IDX_FIELD_W'(pick);
            outcome.granted      = 1'b1;
            outcome.chosen_block = IDX_FIELD_W'(pick);
            outcome.block_left   = free_size[pick];
         end
      end
      // running fragmentation totals, saturated
      in_sum = 0;
      ex_sum = 0;
      for (k = 0; k < NUM_BLOCKS; k++) begin
         ex_sum += free_size[k];
         if (used_flag[k]) in_sum += free_size[k];
      end
      outcome.internal_total = (in_sum > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(in_sum);
      outcome.external_total = (ex_sum > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(ex_sum);
      return outcome;
   endfunction

   task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                              input logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // watch both channels and the register port at every rising edge
   always @(posedge clock) begin : watch
      int      k;
      rsp_type want;
      if (reset) begin
         for (k = 0; k < NUM_BLOCKS; k++) begin
            free_size[k] = '0;
            used_flag[k] = 1'b0;
         end
         last_grant = '0;
         fit_policy = POL_FIRST;
         outcome_fifo.delete();
      end else begin
         // popped item against the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            if (outcome_fifo.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = outcome_fifo.pop_front();
               check_field("granted", TOTAL_W'(want.granted),
                           TOTAL_W'(rsp_data.granted));
               check_field("chosen_block", TOTAL_W'(want.chosen_block),
                           TOTAL_W'(rsp_data.chosen_block));
               check_field("block_left", TOTAL_W'(want.block_left),
                           TOTAL_W'(rsp_data.block_left));
               check_field("internal_total", want.internal_total, rsp_data.internal_total);
               check_field("external_total", want.external_total, rsp_data.external_total);
            end
         end
         // accepted item
         if (req_push && !req_full) begin
            outcome_fifo.push_back(place_item(req_data));
         end
         // policy write
         if (csr_valid && csr_ready) begin
            fit_policy = policy_type'(csr_data);
         end
      end
      pending_count <= outcome_fifo.size();
      fail_count    <= mismatches;
   end

endmodule

[test/fit_policy_block_allocator_tb.sv]
`timescale 1ns / 1ps
// testbench top for the fit-policy block allocator: clock, reset, item and
// policy stimulus with random idling, and the verdict
// depends on fpba_pkg, fpba_result_checker and the block itself
module fit_policy_block_allocator_tb;
   import fpba_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 13;
   localparam int PHASE_ITEMS = 150;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_empty;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data  = POL_FIRST;

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count = 0;
   int          burst_left  = 0;

   fit_policy_block_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   fpba_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // result side: spells of free flow, light stalls and heavy stalls
   initial begin : pop_pattern
      int hold;
      int mode;
      int spell;
      hold  = 0;
      mode  = 0;
      spell = 0;
      forever begin
         @(negedge clock);
         if (spell == 0) begin
            mode  = $urandom_range(0, 2);
            spell = $urandom_range(50, 300);
         end
         spell--;
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (mode == 1 && $urandom_range(0, 3) == 0) begin
               hold = $urandom_range(1, 4);
            end else if (mode == 2 && $urandom_range(0, 1) == 0) begin
               hold = $urandom_range(3, 20);
            end
         end
      end
   end

   // offer one item, called at a falling edge; returns at a falling edge
   task automatic offer_item(input op_type op, input logic [IDX_FIELD_W-1:0] idx,
                             input logic [SIZE_FIELD_W-1:0] amount);
      int gap;
      req_data.action      <= op;
      req_data.block_index <= idx;
      req_data.size        <= amount;
      req_push             <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      // end of burst: idle for a while, then pick the next burst length
      if (burst_left == 0) begin
         req_push <= 1'b0;
         gap = $urandom_range(1, 25);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   // drain all outstanding items, then write the policy register
   task automatic set_policy(input policy_type pol);
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= pol;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // main stimulus
   initial begin : stimulus
      int          phase;
      int          n;
      int          pick;
      op_type      op;
      logic [3:0]  idx;
      logic [15:0] amount;
      policy_type  pol;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first fit from the reset policy: zero-size into an empty table takes block 0, size one finds no fit
      offer_item(OP_ALLOC, 4'd5, 16'd0);
      offer_item(OP_ALLOC, 4'd0, 16'd1);
      offer_item(OP_LOAD, 4'd15, 16'hFFFF);
      offer_item(OP_LOAD, 4'd0, 16'd100);
      offer_item(OP_LOAD, 4'd7, 16'd100);
      offer_item(OP_LOAD, 4'd3, 16'd300);
      offer_item(OP_ALLOC, 4'd15, 16'd100);
      offer_item(OP_ALLOC, 4'd9, 16'hFFFF);

      // best fit, with a tie between two equal blocks
      set_policy(POL_BEST);
      offer_item(OP_LOAD, 4'd0, 16'd50);
      offer_item(OP_LOAD, 4'd8, 16'd64);
      offer_item(OP_LOAD, 4'd9, 16'd64);
      offer_item(OP_ALLOC, 4'd2, 16'd40);
      offer_item(OP_ALLOC, 4'd4, 16'd60);
      offer_item(OP_ALLOC, 4'd11, 16'd100);

      // worst fit, tie goes to the lower index
      set_policy(POL_WORST);
      offer_item(OP_LOAD, 4'd5, 16'd300);
      offer_item(OP_ALLOC, 4'd1, 16'd1);

      // next fit: from the last grant, then around the wrap
      set_policy(POL_NEXT);
      offer_item(OP_ALLOC, 4'd6, 16'd299);
      offer_item(OP_ALLOC, 4'd12, 16'd300);
      offer_item(OP_ALLOC, 4'd3, 16'd5);
      offer_item(OP_ALLOC, 4'd14, 16'hFFFF);
      offer_item(OP_ALLOC, 4'd10, 16'd0);
      offer_item(OP_LOAD, 4'd15, 16'd0);

      // random phases, extremes of the policy first
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       pol = POL_FIRST;
            1:       pol = POL_NEXT;
            2:       pol = POL_BEST;
            3:       pol = POL_WORST;
            default: pol = policy_type'($urandom_range(0, 3));
         endcase
         set_policy(pol);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            op  = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_ALLOC;
            // crowd a few slots now and then so ties and reuse happen
            idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            if (op == OP_LOAD) begin
               case (pick)
                  0:       amount = 16'd0;
                  1:       amount = 16'hFFFF;
                  2, 3:    amount = 16'(64 << $urandom_range(0, 3));
                  4, 5:    amount = 16'($urandom_range(0, 1023));
                  6:       amount = 16'($urandom_range(0, 8191));
                  default: amount = 16'($urandom_range(0, 65535));
               endcase
            end else begin
               case (pick)
                  0:       amount = 16'd0;
                  1:       amount = 16'hFFFF;
                  2, 3, 4: amount = 16'($urandom_range(0, 64));
                  5, 6, 7: amount = 16'($urandom_range(0, 4095));
                  default: amount = 16'($urandom_range(0, 65535));
               endcase
            end
            offer_item(op, idx, amount);
         end
      end

      // drain, let the block settle, then the verdict
      req_push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/fpba_pkg.sv
rtl/fpba_front.sv
rtl/fpba_back.sv
rtl/fit_policy_block_allocator.sv
test/fpba_result_checker.sv
test/fit_policy_block_allocator_tb.sv
